// File: rtl/core/ilck_pkg.sv
package ilck_pkg;

    // item kind carried on s_axis_tuser
    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_MERGED = 2'd2,
        KIND_EVAL   = 2'd3
    } t_kind;

    typedef enum logic {
        TS_IDLE,
        TS_EVAL
    } t_top_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_COL,
        E_ROW_RD,
        E_ROW_EX,
        E_CELL_RD,
        E_CELL_CMP,
        E_CELL_EX,
        E_DONE
    } t_eng_state;

    // store write enables from the load path
    typedef struct packed {
        logic first;
        logic second;
        logic merged;
    } t_load_sel;

    typedef struct packed {
        logic done;
        logic possible;
    } t_eng_status;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OUT_W   = 8;

endpackage

// File: rtl/core/ilck_engine.sv
module ilck_engine #(
    parameter int unsigned MAX_SOURCE_LEN = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ilck_pkg::t_load_sel                    i_load,
    input  logic [$clog2(2*MAX_SOURCE_LEN)-1:0]    i_wr_addr,
    input  logic [ilck_pkg::VALUE_W-1:0]           i_wr_data,
    input  logic                                   i_start,
    input  logic [$clog2(MAX_SOURCE_LEN+1)-1:0]    i_n1,
    input  logic [$clog2(MAX_SOURCE_LEN+1)-1:0]    i_n2,
    output ilck_pkg::t_eng_status                  o_status
);

    localparam int unsigned CW  = $clog2(MAX_SOURCE_LEN + 1);
    localparam int unsigned JW  = CW + 1;
    localparam int unsigned AW  = (MAX_SOURCE_LEN > 1) ? $clog2(MAX_SOURCE_LEN) : 1;
    localparam int unsigned MAW = $clog2(2 * MAX_SOURCE_LEN);
    localparam int unsigned VW  = ilck_pkg::VALUE_W;

    logic [VW-1:0] r_mem_first  [MAX_SOURCE_LEN];
    logic [VW-1:0] r_mem_second [MAX_SOURCE_LEN];
    logic [VW-1:0] r_mem_merged [2*MAX_SOURCE_LEN];
    logic          r_mem_row    [MAX_SOURCE_LEN];

    ilck_pkg::t_eng_state r_state, n_state;
    logic [CW-1:0] r_n1, n_n1, r_n2, n_n2, r_i, n_i;
    logic [JW-1:0] r_j, n_j;
    logic          r_left, n_left, r_row0, n_row0, r_eq_s2, n_eq_s2;
    logic [VW-1:0] r_a, n_a;

    logic [VW-1:0] r_s1_q, r_s2_q, r_m_q;
    logic          r_row_q;

    logic           w_rd_row, w_rd_cell, w_row_we, w_cell, w_eq;
    logic [VW-1:0]  w_cmp_b;
    logic [AW-1:0]  w_s1_raddr, w_s2_raddr, w_row_addr;
    logic [MAW-1:0] w_m_raddr;

    assign w_s1_raddr = AW'(r_i - CW'(1));
    assign w_s2_raddr = AW'(r_j - JW'(1));
    assign w_row_addr = AW'(r_j - JW'(1));
    assign w_m_raddr  = (r_state == ilck_pkg::E_ROW_RD) ? (MAW'(r_i) - MAW'(1))
                      : (MAW'(r_i) + MAW'(r_j) - MAW'(1));

    // the one comparator, shared by row starts and both cell compares
    always_comb begin
        case (r_state)
            ilck_pkg::E_ROW_EX:   w_cmp_b = r_s1_q;
            ilck_pkg::E_CELL_CMP: w_cmp_b = r_s2_q;
            default:              w_cmp_b = r_a;
        endcase
    end
    assign w_eq = (r_m_q == w_cmp_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilck_pkg::E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_n1      = r_n1;
        n_n2      = r_n2;
        n_i       = r_i;
        n_j       = r_j;
        n_left    = r_left;
        n_row0    = r_row0;
        n_eq_s2   = r_eq_s2;
        n_a       = r_a;
        w_rd_row  = 1'b0;
        w_rd_cell = 1'b0;
        w_row_we  = 1'b0;
        w_cell    = 1'b0;
        case (r_state)
            ilck_pkg::E_IDLE: begin
                if (i_start) begin
                    n_n1    = i_n1;
                    n_n2    = i_n2;
                    n_i     = '0;
                    n_j     = JW'(1);
                    n_left  = 1'b1;
                    n_row0  = 1'b1;
                    n_state = ilck_pkg::E_COL;
                end
            end
            ilck_pkg::E_COL: begin
                if (r_j > {1'b0, r_n2}) begin
                    if (r_i == r_n1) begin
                        n_state = ilck_pkg::E_DONE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = ilck_pkg::E_ROW_RD;
                    end
                end else begin
                    n_state = ilck_pkg::E_CELL_RD;
                end
            end
            ilck_pkg::E_ROW_RD: begin
                w_rd_row = 1'b1;
                n_state  = ilck_pkg::E_ROW_EX;
            end
            ilck_pkg::E_ROW_EX: begin
                // left column: whole first-source prefix must match
                n_a     = r_s1_q;
                n_row0  = r_row0 && w_eq;
                n_left  = r_row0 && w_eq;
                n_j     = JW'(1);
                n_state = ilck_pkg::E_COL;
            end
            ilck_pkg::E_CELL_RD: begin
                w_rd_cell = 1'b1;
                n_state   = ilck_pkg::E_CELL_CMP;
            end
            ilck_pkg::E_CELL_CMP: begin
                n_eq_s2 = w_eq;
                n_state = ilck_pkg::E_CELL_EX;
            end
            ilck_pkg::E_CELL_EX: begin
                // top row only extends from the left
                if (r_i == '0) begin
                    w_cell = r_left && r_eq_s2;
                end else begin
                    w_cell = (w_eq && r_row_q) || (r_eq_s2 && r_left);
                end
                w_row_we = 1'b1;
                n_left   = w_cell;
                n_j      = r_j + JW'(1);
                n_state  = ilck_pkg::E_COL;
            end
            ilck_pkg::E_DONE: begin
                n_state = ilck_pkg::E_IDLE;
            end
            default: begin
                n_state = ilck_pkg::E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n1    <= n_n1;
        r_n2    <= n_n2;
        r_i     <= n_i;
        r_j     <= n_j;
        r_left  <= n_left;
        r_row0  <= n_row0;
        r_eq_s2 <= n_eq_s2;
        r_a     <= n_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.first) begin
            r_mem_first[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (w_rd_row) begin
            r_s1_q <= r_mem_first[w_s1_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.second) begin
            r_mem_second[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (w_rd_cell) begin
            r_s2_q <= r_mem_second[w_s2_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.merged) begin
            r_mem_merged[i_wr_addr] <= i_wr_data;
        end
        if (w_rd_row || w_rd_cell) begin
            r_m_q <= r_mem_merged[w_m_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_mem_row[w_row_addr] <= w_cell;
        end
        if (w_rd_cell) begin
            r_row_q <= r_mem_row[w_row_addr];
        end
    end

    assign o_status.done     = (r_state == ilck_pkg::E_DONE);
    assign o_status.possible = r_left;

endmodule

// File: rtl/core/interleave_check_top.sv
// Interleave checker: load transfers (tuser kind first, second or merged) append the 16-bit
// tdata value to one of three stores and are taken one per cycle with no result. An
// evaluate transfer yields one result: possible in bit 0 and length_error in bit 1 of
// m_axis_tdata, after which all counts and the overflow flag are cleared. A length mismatch
// or an earlier store overflow gives the result in the cycle after the evaluate; otherwise the
// table walk over source lengths n1 and n2 runs on one shared 16-bit comparator and block
// memories with registered reads, and no transfer is accepted until it finishes. Loads are
// still taken while a result waits on the output.
module interleave_check_top #(
    parameter int unsigned MAX_SOURCE_LEN = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ilck_pkg::VALUE_W-1:0]   s_axis_tdata,   // [15:0] value
    input  logic [ilck_pkg::KIND_W-1:0]    s_axis_tuser,   // [1:0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ilck_pkg::OUT_W-1:0]     m_axis_tdata    // [0] possible, [1] length_error
);

    localparam int unsigned CW  = $clog2(MAX_SOURCE_LEN + 1);
    localparam int unsigned MCW = $clog2(2 * MAX_SOURCE_LEN + 1);
    localparam int unsigned MAW = $clog2(2 * MAX_SOURCE_LEN);

    ilck_pkg::t_top_state  r_state, n_state;
    logic [CW-1:0]         r_n1, n_n1, r_n2, n_n2;
    logic [MCW-1:0]        r_nm, n_nm;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic                  r_possible, n_possible, r_len_err, n_len_err;

    ilck_pkg::t_kind       w_kind;
    ilck_pkg::t_load_sel   w_load;
    ilck_pkg::t_eng_status w_status;
    logic [MAW-1:0]        w_wr_addr;
    logic                  w_start, w_s_fire, w_err;

    assign w_kind        = ilck_pkg::t_kind'(s_axis_tuser);
    assign s_axis_tready = (r_state == ilck_pkg::TS_IDLE)
                        && !(r_out_valid && (w_kind == ilck_pkg::KIND_EVAL));
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;
    assign w_err         = r_ovf || (r_nm != (MCW'(r_n1) + MCW'(r_n2)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilck_pkg::TS_IDLE;
            r_n1        <= '0;
            r_n2        <= '0;
            r_nm        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n1        <= n_n1;
            r_n2        <= n_n2;
            r_nm        <= n_nm;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_possible <= n_possible;
        r_len_err  <= n_len_err;
    end

    always_comb begin
        n_state     = r_state;
        n_n1        = r_n1;
        n_n2        = r_n2;
        n_nm        = r_nm;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_possible  = r_possible;
        n_len_err   = r_len_err;
        w_load      = '0;
        w_wr_addr   = '0;
        w_start     = 1'b0;
        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ilck_pkg::TS_IDLE: begin
                if (w_s_fire) begin
                    case (w_kind)
                        ilck_pkg::KIND_FIRST: begin
                            if (r_n1 < CW'(MAX_SOURCE_LEN)) begin
                                w_load.first = 1'b1;
                                w_wr_addr    = MAW'(r_n1);
                                n_n1         = r_n1 + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ilck_pkg::KIND_SECOND: begin
                            if (r_n2 < CW'(MAX_SOURCE_LEN)) begin
                                w_load.second = 1'b1;
                                w_wr_addr     = MAW'(r_n2);
                                n_n2          = r_n2 + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ilck_pkg::KIND_MERGED: begin
                            if (r_nm < MCW'(2 * MAX_SOURCE_LEN)) begin
                                w_load.merged = 1'b1;
                                w_wr_addr     = MAW'(r_nm);
                                n_nm          = r_nm + MCW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ilck_pkg::KIND_EVAL: begin
                            n_n1  = '0;
                            n_n2  = '0;
                            n_nm  = '0;
                            n_ovf = 1'b0;
                            if (w_err) begin
                                n_out_valid = 1'b1;
                                n_possible  = 1'b0;
                                n_len_err   = 1'b1;
                            end else begin
                                w_start = 1'b1;
                                n_state = ilck_pkg::TS_EVAL;
                            end
                        end
                        default: begin
                            n_state = ilck_pkg::TS_IDLE;
                        end
                    endcase
                end
            end
            ilck_pkg::TS_EVAL: begin
                if (w_status.done) begin
                    n_out_valid = 1'b1;
                    n_possible  = w_status.possible;
                    n_len_err   = 1'b0;
                    n_state     = ilck_pkg::TS_IDLE;
                end
            end
            default: begin
                n_state = ilck_pkg::TS_IDLE;
            end
        endcase
    end

    ilck_engine #(
        .MAX_SOURCE_LEN (MAX_SOURCE_LEN)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_start   (w_start),
        .i_n1      (r_n1),
        .i_n2      (r_n2),
        .o_status  (w_status)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ilck_pkg::OUT_W - 2){1'b0}}, r_len_err, r_possible};

    a_done_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (r_state == ilck_pkg::TS_EVAL))
        else $error("engine finished outside an evaluation");

    a_err_not_possible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_len_err && r_possible))
        else $error("result flags both possible and length error");

    a_eval_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && (w_kind == ilck_pkg::KIND_EVAL))
        |=> (r_n1 == '0 && r_n2 == '0 && r_nm == '0 && !r_ovf))
        else $error("counts not cleared after evaluate");

    a_start_frees_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !r_out_valid)
        else $error("evaluation started while a result is pending");

endmodule

// File: tb/tb_interleave_check_top.sv
module tb_interleave_check_top;

    localparam int unsigned MAX_SRC      = 1024;
    localparam int unsigned LIMIT_CYCLES = 2_500_000;

    typedef struct {
        ilck_pkg::t_kind kind;
        logic [15:0]     value;
        bit              drain;    // hold this transfer until every verdict has come back
    } t_feed;

    typedef struct packed {
        logic possible;
        logic length_error;
    } t_verdict;

    typedef enum int {
        FLAW_NONE,
        FLAW_ALTER,
        FLAW_SWAP,
        FLAW_SHORT,
        FLAW_LONG
    } t_flaw;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ilck_pkg::VALUE_W-1:0]   s_axis_tdata = '0;    // [15:0] value
    logic [ilck_pkg::KIND_W-1:0]    s_axis_tuser = '0;    // [1:0] kind
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ilck_pkg::OUT_W-1:0]     m_axis_tdata;         // [0] possible, [1] length_error

    interleave_check_top #(
        .MAX_SOURCE_LEN(MAX_SRC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    t_feed       feed_queue[$];
    t_verdict    verdicts_due[$];
    int unsigned feed_total;
    int unsigned accepted_feeds;
    int unsigned mismatches;
    int unsigned loads_seen, evals_seen, interleaved_seen, error_seen, results_checked;

    // shadow copy of the three stores, their fill counts and the overflow flag
    logic [15:0] seq_first  [MAX_SRC];
    logic [15:0] seq_second [MAX_SRC];
    logic [15:0] seq_merged [2*MAX_SRC];
    int unsigned len_first, len_second, len_merged;
    bit          spilled;

    int unsigned send_gap, send_burst, recv_stall, recv_calm;

    function automatic bit interleave_ok();
        bit          row [MAX_SRC+1];
        logic [15:0] a;
        row[0] = 1'b1;
        for (int j = 1; j <= len_second; j++)
            row[j] = row[j-1] && (seq_second[j-1] == seq_merged[j-1]);
        for (int i = 1; i <= len_first; i++) begin
            a = seq_first[i-1];
            row[0] = row[0] && (a == seq_merged[i-1]);
            for (int j = 1; j <= len_second; j++)
                row[j] = (seq_merged[i+j-1] == a && row[j])
                      || (seq_merged[i+j-1] == seq_second[j-1] && row[j-1]);
        end
        return row[len_second];
    endfunction

    function automatic void take_item(ilck_pkg::t_kind kind, logic [15:0] value);
        t_verdict v;
        case (kind)
            ilck_pkg::KIND_FIRST: begin
                if (len_first < MAX_SRC) begin
                    seq_first[len_first] = value;
                    len_first++;
                end else spilled = 1'b1;
            end
            ilck_pkg::KIND_SECOND: begin
                if (len_second < MAX_SRC) begin
                    seq_second[len_second] = value;
                    len_second++;
                end else spilled = 1'b1;
            end
            ilck_pkg::KIND_MERGED: begin
                if (len_merged < 2*MAX_SRC) begin
                    seq_merged[len_merged] = value;
                    len_merged++;
                end else spilled = 1'b1;
            end
            default: begin
                v.length_error = spilled || (len_merged != len_first + len_second);
                v.possible     = v.length_error ? 1'b0 : interleave_ok();
                verdicts_due.insert(verdicts_due.size(), v);
                evals_seen++;
                interleaved_seen += v.possible;
                error_seen       += v.length_error;
                len_first  = 0;
                len_second = 0;
                len_merged = 0;
                spilled    = 1'b0;
            end
        endcase
        if (kind != ilck_pkg::KIND_EVAL) loads_seen++;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 6);
        return $urandom_range(7, 16);
    endfunction

    function automatic void feed(ilck_pkg::t_kind kind, logic [15:0] value, bit drain = 1'b0);
        t_feed f;
        f.kind  = kind;
        f.value = value;
        f.drain = drain;
        feed_queue.insert(feed_queue.size(), f);
    endfunction

    // two sources and a merge of them, optionally damaged, loaded in a shuffled kind order
    function automatic void queue_case(int n1, int n2, t_flaw flaw, bit drain);
        logic [15:0] syms [4];
        logic [15:0] a [$];
        logic [15:0] b [$];
        logic [15:0] m [$];
        logic [15:0] tmp;
        int          k, ia, ib, im, pos, pick;
        bit          wild, lead;
        k    = $urandom_range(1, 4);
        wild = ($urandom_range(0, 4) == 0);
        foreach (syms[s]) syms[s] = 16'($urandom);
        for (int i = 0; i < n1; i++)
            a.insert(a.size(), wild ? 16'($urandom) : syms[$urandom_range(0, k-1)]);
        for (int i = 0; i < n2; i++)
            b.insert(b.size(), wild ? 16'($urandom) : syms[$urandom_range(0, k-1)]);
        ia = 0;
        ib = 0;
        while (ia < n1 || ib < n2) begin
            if (ib >= n2 || (ia < n1 && $urandom_range(0, 1))) begin
                m.insert(m.size(), a[ia]);
                ia++;
            end else begin
                m.insert(m.size(), b[ib]);
                ib++;
            end
        end
        case (flaw)
            FLAW_ALTER: if (m.size() > 0) begin
                pos = $urandom_range(0, m.size() - 1);
                m[pos] = m[pos] ^ (16'h1 << $urandom_range(0, 15));
            end
            FLAW_SWAP: if (m.size() > 1) begin
                pos      = $urandom_range(0, m.size() - 2);
                tmp      = m[pos];
                m[pos]   = m[pos+1];
                m[pos+1] = tmp;
            end
            FLAW_SHORT: begin
                if (m.size() > 0) m.delete($urandom_range(0, m.size() - 1));
                else m.insert(0, syms[0]);
            end
            FLAW_LONG: m.insert($urandom_range(0, m.size()), syms[$urandom_range(0, k-1)]);
            default: ;
        endcase
        ia   = 0;
        ib   = 0;
        im   = 0;
        lead = drain;
        while (ia < a.size() || ib < b.size() || im < m.size()) begin
            pick = $urandom_range(0, 2);
            if (pick == 0 && ia < a.size()) begin
                feed(ilck_pkg::KIND_FIRST, a[ia], lead);
                ia++;
                lead = 1'b0;
            end else if (pick == 1 && ib < b.size()) begin
                feed(ilck_pkg::KIND_SECOND, b[ib], lead);
                ib++;
                lead = 1'b0;
            end else if (pick == 2 && im < m.size()) begin
                feed(ilck_pkg::KIND_MERGED, m[im], lead);
                im++;
                lead = 1'b0;
            end
        end
        feed(ilck_pkg::KIND_EVAL, 16'($urandom), lead);
    endfunction

    // loads of random kinds with unrelated values, then an evaluate
    function automatic void queue_noise();
        repeat ($urandom_range(0, 12))
            feed(ilck_pkg::t_kind'(2'($urandom_range(0, 2))), 16'($urandom));
        feed(ilck_pkg::KIND_EVAL, 16'($urandom));
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (feed_queue.size() != 0 && !(feed_queue[0].drain
                    && (verdicts_due.size() != 0
                        || (s_axis_tvalid && s_axis_tready
                            && s_axis_tuser == ilck_pkg::KIND_EVAL)))) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= feed_queue[0].kind;
                s_axis_tdata  <= feed_queue[0].value;
                void'(feed_queue.pop_front());
                if (send_burst != 0) begin
                    send_gap   <= 0;
                    send_burst <= send_burst - 1;
                end else begin
                    if ($urandom_range(0, 99) < 3) send_burst <= $urandom_range(40, 120);
                    send_gap <= pick_idle();
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
            recv_calm     <= 0;
        end else if (recv_calm != 0) begin
            m_axis_tready <= 1'b1;
            recv_calm     <= recv_calm - 1;
        end else if (recv_stall != 0) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 2) recv_calm <= $urandom_range(200, 800);
            else if ($urandom_range(0, 99) < 30) recv_stall <= pick_idle();
        end
    end

    // both sides sampled at the edge; results checked before the new transfer is predicted
    always @(posedge i_clk) begin : watch_p
        t_verdict want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result transfer with no evaluate pending, tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== want.possible) begin
                        $error("possible: expected %0b, got %0b", want.possible, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[1] !== want.length_error) begin
                        $error("length_error: expected %0b, got %0b",
                               want.length_error, m_axis_tdata[1]);
                        mismatches++;
                    end
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_item(ilck_pkg::t_kind'(s_axis_tuser), s_axis_tdata);
                accepted_feeds++;
            end
        end
    end

    initial begin
        int unsigned rand_feeds, q0, r;
        t_flaw       flaw;
        bit          drain;

        // empty sources and empty merge
        feed(ilck_pkg::KIND_EVAL, 16'hFFFF);
        // first source only, then second source only
        feed(ilck_pkg::KIND_FIRST, 16'hFFFF);
        feed(ilck_pkg::KIND_MERGED, 16'hFFFF);
        feed(ilck_pkg::KIND_EVAL, 16'h0000);
        feed(ilck_pkg::KIND_SECOND, 16'h0000);
        feed(ilck_pkg::KIND_MERGED, 16'h0000);
        feed(ilck_pkg::KIND_EVAL, 16'h5A5A);
        // merge shorter than the sources
        feed(ilck_pkg::KIND_FIRST, 16'h1234);
        feed(ilck_pkg::KIND_EVAL, 16'h0000);
        // same value in both sources, either order works
        feed(ilck_pkg::KIND_MERGED, 16'hA5A5);
        feed(ilck_pkg::KIND_FIRST, 16'hA5A5);
        feed(ilck_pkg::KIND_SECOND, 16'hA5A5);
        feed(ilck_pkg::KIND_MERGED, 16'hA5A5);
        feed(ilck_pkg::KIND_EVAL, 16'hFFFF);
        // first source order broken in the merge
        feed(ilck_pkg::KIND_FIRST, 16'h0001);
        feed(ilck_pkg::KIND_FIRST, 16'h0002);
        feed(ilck_pkg::KIND_SECOND, 16'h0003);
        feed(ilck_pkg::KIND_MERGED, 16'h0003);
        feed(ilck_pkg::KIND_MERGED, 16'h0002);
        feed(ilck_pkg::KIND_MERGED, 16'h0001);
        feed(ilck_pkg::KIND_EVAL, 16'h0000);
        // merge with no sources
        feed(ilck_pkg::KIND_MERGED, 16'h8000);
        feed(ilck_pkg::KIND_EVAL, 16'h7FFF);

        rand_feeds = 0;
        for (int part = 0; part < 2; part++) begin
            while (rand_feeds < (part + 1) * 400) begin
                q0    = feed_queue.size();
                r     = $urandom_range(0, 99);
                drain = ($urandom_range(0, 9) == 0);
                if (r >= 86) begin
                    queue_noise();
                end else begin
                    flaw = (r < 50) ? FLAW_NONE  : (r < 65) ? FLAW_ALTER :
                           (r < 73) ? FLAW_SWAP  : (r < 80) ? FLAW_SHORT : FLAW_LONG;
                    queue_case(pick_len(), pick_len(), flaw, drain);
                end
                rand_feeds += feed_queue.size() - q0;
            end
            if (part == 0) begin
                // first store filled to the limit, then one load past it
                feed(ilck_pkg::KIND_FIRST, 16'($urandom), 1'b1);
                repeat (MAX_SRC) feed(ilck_pkg::KIND_FIRST, 16'($urandom));
                feed(ilck_pkg::KIND_EVAL, 16'($urandom));
            end
        end
        feed_total = feed_queue.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_feeds != feed_total) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("covered %0d loads and %0d evaluates (%0d interleavings, %0d length errors)",
                 loads_seen, evals_seen, interleaved_seen, error_seen);
        $display("%0d result transfers checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("interleave_check_top regression: pass");
        end else begin
            $display("interleave_check_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 4);
        $display("timeout with %0d results outstanding", verdicts_due.size());
        $display("interleave_check_top regression: fail");
        $finish;
    end

endmodule
